### sv/sat_pkg.sv
// Shared types, constants and helpers for the section address translator.
`timescale 1ns / 1ps

package sat_pkg;

    // Table geometry
    localparam int MAX_SECTIONS = 16;
    localparam int SEC_IDX_W    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTIONS    = 2'd2;

    // Command codes
    localparam logic CMD_WRITE     = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    // Characteristics flag bits
    localparam int FLAG_EXECUTE_BIT = 29;
    localparam int FLAG_READ_BIT    = 30;
    localparam int FLAG_WRITE_BIT   = 31;

    // Bit positions in the packed rights field
    localparam int RIGHT_READ    = 0;
    localparam int RIGHT_WRITE   = 1;
    localparam int RIGHT_EXECUTE = 2;

    typedef enum logic [2:0] {
        OUT_HEADER   = 3'd0,
        OUT_BACKED   = 3'd1,
        OUT_ZERO     = 3'd2,
        OUT_UNMAPPED = 3'd3,
        OUT_PAST_END = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_RESULT = 2'd1,
        OP_SEARCH = 2'd2
    } op_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE  = 3'd0,
        BK_FETCH = 3'd1,
        BK_SPAN  = 3'd2,
        BK_HIT   = 3'd3,
        BK_POS   = 3'd4,
        BK_EMIT  = 3'd5
    } back_state_t;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] vsize;
        logic [31:0] rsize;
        logic [31:0] roffset;
        logic [2:0]  rights;
    } entry_t;

    typedef struct packed {
        outcome_t               outcome;
        logic [31:0]            offset;
        logic [SEC_IDX_W-1:0]   section;
        logic [2:0]             rights;
    } result_t;

    typedef struct packed {
        op_kind_t               kind;
        logic [SEC_IDX_W-1:0]   slot;
        entry_t                 entry;
        logic [31:0]            addr;
        result_t                res;
    } q_item_t;

    typedef struct packed {
        logic [31:0]      header_size;
        logic [31:0]      file_length;
        logic [CNT_W-1:0] count;
    } cfg_t;

    // Pack read, write and execute rights from a characteristics word
    function automatic logic [2:0] rights_of(input logic [31:0] flags);
        logic [2:0] r;
        r                = '0;
        r[RIGHT_READ]    = flags[FLAG_READ_BIT];
        r[RIGHT_WRITE]   = flags[FLAG_WRITE_BIT];
        r[RIGHT_EXECUTE] = flags[FLAG_EXECUTE_BIT];
        return r;
    endfunction

endpackage

### sv/sat_front.sv
// Front end: configuration registers, input acceptance and command classification.
`timescale 1ns / 1ps

module sat_front
    import sat_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [3:0]           entry_index,
    input  logic [31:0]          section_base,
    input  logic [31:0]          section_virtual_size,
    input  logic [31:0]          section_raw_size,
    input  logic [31:0]          section_raw_offset,
    input  logic [31:0]          section_characteristics,
    input  logic [31:0]          lookup_address,
    input  logic                 q_full,
    output logic                 q_push,
    output q_item_t              q_item,
    output cfg_t                 cfg
);

    logic [31:0]      header_size_reg;
    logic [31:0]      file_length_reg;
    logic [CNT_W-1:0] count_reg;
    logic             accept;
    logic             slot_ok;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && !q_full;
    assign slot_ok   = 32'(entry_index) < MAX_SECTIONS;

    // Write configuration; clamp the low five bits of the section count to the table depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_size_reg <= '0;
            file_length_reg <= '0;
            count_reg       <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HEADER_SIZE: header_size_reg <= cfg_data;
                CFG_FILE_LENGTH: file_length_reg <= cfg_data;
                CFG_SECTIONS:
                begin
                    if (32'(cfg_data[4:0]) > MAX_SECTIONS)
                        count_reg <= CNT_W'(MAX_SECTIONS);
                    else
                        count_reg <= CNT_W'(cfg_data[4:0]);
                end
                default: ;
            endcase
        end
    end

    assign cfg.header_size = header_size_reg;
    assign cfg.file_length = file_length_reg;
    assign cfg.count       = count_reg;

    // Classify: table write, header hit answered here, or table search
    always_comb
    begin
        q_item                = '0;
        q_item.slot           = SEC_IDX_W'(entry_index);
        q_item.entry.base     = section_base;
        q_item.entry.vsize    = section_virtual_size;
        q_item.entry.rsize    = section_raw_size;
        q_item.entry.roffset  = section_raw_offset;
        q_item.entry.rights   = rights_of(section_characteristics);
        q_item.addr           = lookup_address;
        q_item.res.outcome    = OUT_PAST_END;
        q_push                = 1'b0;

        if (command == CMD_WRITE)
        begin
            q_item.kind = OP_WRITE;
            q_push      = accept && slot_ok;
        end
        else if (lookup_address < header_size_reg)
        begin
            q_item.kind = OP_RESULT;
            q_push      = accept;
            if (lookup_address < file_length_reg)
            begin
                q_item.res.outcome = OUT_HEADER;
                q_item.res.offset  = lookup_address;
            end
        end
        else
        begin
            q_item.kind = OP_SEARCH;
            q_push      = accept;
        end
    end

endmodule

### sv/sat_queue.sv
// Short command queue that decouples the front end from the table walker.
`timescale 1ns / 1ps

module sat_queue
    import sat_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    output logic    full,
    input  logic    pop,
    output logic    empty,
    output q_item_t head
);

    q_item_t           items_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = fill_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty   = fill_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = items_reg[rd_ptr_reg];

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (do_push)
            items_reg[wr_ptr_reg] <= push_item;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

### sv/sat_back.sv
// Back end: section table memory, sequential table walk and result register.
`timescale 1ns / 1ps

module sat_back
    import sat_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_empty,
    input  q_item_t q_head,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    entry_t               mem [MAX_SECTIONS];
    back_state_t          state_reg;
    back_state_t          state_next;
    logic [SEC_IDX_W-1:0] idx_reg;
    logic [SEC_IDX_W-1:0] idx_next;
    logic [31:0]          addr_reg;
    logic [31:0]          addr_next;
    result_t              res_reg;
    result_t              res_next;
    result_t              out_res_reg;
    logic                 out_valid_reg;
    entry_t               rd_reg;
    logic [31:0]          end_reg;
    logic                 ge_reg;
    logic [31:0]          off_reg;
    logic [32:0]          pos_reg;
    logic                 inraw_reg;
    logic [31:0]          span;
    logic                 hit;
    logic                 last;
    logic                 out_free;
    logic                 mem_we;
    logic                 out_load;
    result_t              unmapped_res;

    assign out_free  = !out_valid_reg || out_ready;
    assign hit       = ge_reg && (addr_reg < end_reg);
    assign last      = (CNT_W'(idx_reg) + CNT_W'(1)) == cfg.count;
    assign span      = (rd_reg.vsize > rd_reg.rsize) ? rd_reg.vsize : rd_reg.rsize;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        unmapped_res         = '0;
        unmapped_res.outcome = OUT_UNMAPPED;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_head.kind)
                        OP_RESULT: state_next = BK_EMIT;
                        OP_SEARCH: state_next = (cfg.count == '0) ? BK_EMIT : BK_FETCH;
                        default:   state_next = BK_IDLE;
                    endcase
                end
            end
            BK_FETCH: state_next = BK_SPAN;
            BK_SPAN:  state_next = BK_HIT;
            BK_HIT:
            begin
                if (hit)
                    state_next = BK_POS;
                else if (last)
                    state_next = BK_EMIT;
                else
                    state_next = BK_FETCH;
            end
            BK_POS:   state_next = BK_EMIT;
            BK_EMIT:  state_next = out_free ? BK_IDLE : BK_EMIT;
            default:  state_next = BK_IDLE;
        endcase
    end

    // Control outputs and datapath next values
    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        out_load  = 1'b0;
        idx_next  = idx_reg;
        addr_next = addr_reg;
        res_next  = res_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    mem_we    = q_head.kind == OP_WRITE;
                    addr_next = q_head.addr;
                    idx_next  = '0;
                    if (q_head.kind == OP_RESULT)
                        res_next = q_head.res;
                    else
                        res_next = unmapped_res;
                end
            end
            BK_HIT:
            begin
                if (!hit)
                begin
                    res_next = unmapped_res;
                    if (!last)
                        idx_next = idx_reg + 1'b1;
                end
            end
            BK_POS:
            begin
                res_next         = '0;
                res_next.section = idx_reg;
                res_next.rights  = rd_reg.rights;
                if (!inraw_reg)
                    res_next.outcome = OUT_ZERO;
                else if (pos_reg < {1'b0, cfg.file_length})
                begin
                    res_next.outcome = OUT_BACKED;
                    res_next.offset  = pos_reg[31:0];
                end
                else
                    res_next.outcome = OUT_PAST_END;
            end
            BK_EMIT:
                out_load = out_free;
            default: ;
        endcase
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[q_head.slot] <= q_head.entry;
        rd_reg <= mem[idx_reg];
    end

    // Per-entry compare pipeline: span end, then hit, then file position
    always_ff @(posedge clk)
    begin
        end_reg   <= rd_reg.base + span;
        ge_reg    <= addr_reg >= rd_reg.base;
        off_reg   <= addr_reg - rd_reg.base;
        pos_reg   <= {1'b0, rd_reg.roffset} + {1'b0, off_reg};
        inraw_reg <= off_reg < rd_reg.rsize;
        addr_reg  <= addr_next;
        res_reg   <= res_next;
        if (out_load)
            out_res_reg <= res_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

### sv/section_address_translator.sv
// Top level of the section address translator.
`timescale 1ns / 1ps
// Usage:
//   Load header_size, file_length and sections_in_use through the cfg port
//   (cfg_ready is always high) while the block is idle. Send write commands
//   to fill section entries, then translate commands with lookup_address.
//   Each translate returns one transfer on the out channel; writes return none.
// Flow:
//   A write is stored in the table when the walker pops it. An address under
//   header_size is answered by the front end without a table search. A table
//   search walks the entries in order, one at a time through the table read
//   port, taking each entry examined through its fetch, span and hit steps;
//   a hit adds a position step before emit, a miss emits after the last entry.
//   The two-entry command queue lets new items be accepted while the walker
//   is busy or a result waits in the output register.
// Reset:
//   Clears the configuration registers, queue and walker. Table contents are
//   undefined until written.
// Stall:
//   A stalled receiver holds the result; the walker then stops in its emit
//   step, the queue fills and in_ready drops.

module section_address_translator
    import sat_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [3:0]           entry_index,
    input  logic [31:0]          section_base,
    input  logic [31:0]          section_virtual_size,
    input  logic [31:0]          section_raw_size,
    input  logic [31:0]          section_raw_offset,
    input  logic [31:0]          section_characteristics,
    input  logic [31:0]          lookup_address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           outcome,
    output logic [31:0]          byte_offset,
    output logic [3:0]           matched_section,
    output logic                 can_read,
    output logic                 can_write,
    output logic                 can_execute
);

    cfg_t    cfg;
    q_item_t push_item;
    q_item_t head;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    result_t out_res;

    sat_front u_front (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cfg_valid               (cfg_valid),
        .cfg_ready               (cfg_ready),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data),
        .in_valid                (in_valid),
        .in_ready                (in_ready),
        .command                 (command),
        .entry_index             (entry_index),
        .section_base            (section_base),
        .section_virtual_size    (section_virtual_size),
        .section_raw_size        (section_raw_size),
        .section_raw_offset      (section_raw_offset),
        .section_characteristics (section_characteristics),
        .lookup_address          (lookup_address),
        .q_full                  (q_full),
        .q_push                  (q_push),
        .q_item                  (push_item),
        .cfg                     (cfg)
    );

    sat_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (head)
    );

    sat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_head    (head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    // Drive result fields
    assign outcome         = out_res.outcome;
    assign byte_offset     = out_res.offset;
    assign matched_section = 4'(out_res.section);
    assign can_read        = out_res.rights[RIGHT_READ];
    assign can_write       = out_res.rights[RIGHT_WRITE];
    assign can_execute     = out_res.rights[RIGHT_EXECUTE];

endmodule

### sv/sat_checker.sv
// Port-level checks for the section address translator, bound to the top level.
`timescale 1ns / 1ps

module sat_checker
    import sat_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [2:0]           outcome,
    input logic [31:0]          byte_offset,
    input logic [3:0]           matched_section,
    input logic                 can_read,
    input logic                 can_write,
    input logic                 can_execute
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(byte_offset)
            && $stable(matched_section))
        else $error("result changed while stalled");

    // Unmapped results carry no offset, section or rights
    a_unmapped_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome == OUT_UNMAPPED) |-> (byte_offset == '0)
            && (matched_section == '0) && !can_read && !can_write && !can_execute)
        else $error("unmapped result has stray fields");

    // Header-mapped results name no section
    a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome == OUT_HEADER) |-> (matched_section == '0)
            && !can_read && !can_write && !can_execute)
        else $error("header result names a section");

    // Zero tail and past-end results report no offset
    a_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((outcome == OUT_ZERO) || (outcome == OUT_PAST_END))
            |-> byte_offset == '0)
        else $error("offset reported without file backing");

    // No result right after a reset edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high in reset");

endmodule

bind section_address_translator sat_checker u_sat_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .outcome         (outcome),
    .byte_offset     (byte_offset),
    .matched_section (matched_section),
    .can_read        (can_read),
    .can_write       (can_write),
    .can_execute     (can_execute)
);
